/* rtl/bsde_pkg.sv */
package bsde_pkg;

    localparam int NBINS = 128;
    localparam int BW    = $clog2(NBINS + 1);
    localparam int AW    = $clog2(NBINS);
    localparam int SW    = 10;

    localparam logic [14:0] MEAN_INIT  = 15'd10240;
    localparam logic [14:0] MAXQ9      = 15'd16384;
    localparam logic [14:0] P_OFFSET   = 15'd1024;
    localparam logic [14:0] P_LOWER    = 15'd8704;
    localparam logic [14:0] P_SPREAD   = 15'd2816;
    localparam logic [25:0] H_MAX      = 26'd49152000;
    localparam logic [25:0] H_SAT      = 26'd67108863;
    localparam logic [21:0] H_LASTMAX  = 22'd4096000;
    localparam logic [25:0] H_MINTHR   = 26'd24576;
    localparam logic [10:0] MIN_HITS   = 11'd10;
    localparam logic [10:0] HITS_NC    = 11'd10;
    localparam logic [10:0] HITS_C     = 11'd1000;
    localparam logic [10:0] HIT_SAT    = 11'd2047;
    localparam logic [16:0] FRAC_ONE   = 17'd65536;
    localparam logic [16:0] FRAC_CAUS  = 17'd32768;
    localparam logic [16:0] FRAC_NCAUS = 17'd16384;
    localparam logic [11:0] FRAC_SLOPE = 12'd3277;
    localparam logic [7:0]  NO_DELAY   = 8'hFE;

    typedef struct packed {
        logic [14:0] mean;
        logic [25:0] hist;
    } t_bin;

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [31:0] t;
        t = v - ((v >> 1) & 32'o33333333333) - ((v >> 2) & 32'o11111111111);
        t = (t + (t >> 3)) & 32'o30707070707;
        t = t + (t >> 6);
        t = (t + (t >> 12) + (t >> 24)) & 32'o77;
        return t[5:0];
    endfunction

endpackage

/* rtl/bsde_far_ram.sv */
module bsde_far_ram (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [31:0]             i_spec,
    input  logic [bsde_pkg::AW-1:0] i_age,
    output logic [31:0]             o_hist,
    output logic [5:0]              o_pop
);

    logic [37:0]             mem [bsde_pkg::NBINS];
    logic [bsde_pkg::AW-1:0] r_head, n_head;
    logic [bsde_pkg::BW-1:0] r_fill;
    logic [bsde_pkg::AW-1:0] rd_addr;
    logic [37:0]             r_rd;
    logic                    r_rd_ok;

    always_comb begin
        if (r_head == bsde_pkg::AW'(bsde_pkg::NBINS - 1)) begin
            n_head = '0;
        end else begin
            n_head = r_head + 1'b1;
        end
        if (r_head >= i_age) begin
            rd_addr = r_head - i_age;
        end else begin
            rd_addr = bsde_pkg::AW'((bsde_pkg::BW + 1)'(r_head)
                      + (bsde_pkg::BW + 1)'(bsde_pkg::NBINS)
                      - (bsde_pkg::BW + 1)'(i_age));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_fill  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= bsde_pkg::BW'(i_age) < r_fill;
            if (i_push) begin
                r_head <= n_head;
                if (r_fill != bsde_pkg::BW'(bsde_pkg::NBINS)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[n_head] <= {i_spec, bsde_pkg::popcount32(i_spec)};
        end
        r_rd <= mem[rd_addr];
    end

    assign o_hist = r_rd_ok ? r_rd[37:6] : 32'd0;
    assign o_pop  = r_rd_ok ? r_rd[5:0]  : 6'd0;

endmodule

/* rtl/bsde_bin_ram.sv */
module bsde_bin_ram (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [bsde_pkg::BW-1:0] i_waddr,
    input  bsde_pkg::t_bin          i_wdata,
    input  logic [bsde_pkg::BW-1:0] i_raddr,
    output bsde_pkg::t_bin          o_rdata
);

    bsde_pkg::t_bin mem [bsde_pkg::NBINS + 1];
    logic [bsde_pkg::NBINS:0] r_vld;
    bsde_pkg::t_bin           r_rd;
    logic                     r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_raddr];
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rd <= mem[i_raddr];
    end

    always_comb begin
        if (r_rd_vld) begin
            o_rdata = r_rd;
        end else begin
            o_rdata.mean = bsde_pkg::MEAN_INIT;
            o_rdata.hist = '0;
        end
    end

endmodule

/* rtl/binary_spectrum_delay_estimator_top.sv */
// binary spectrum echo delay estimator
// input channel (i_in_valid / o_in_ready) carries i_action and i_spectrum.
// a far beat (action 0) pushes the spectrum into the far history and
// gives no result; while idle a far beat can be taken every cycle.
// a near beat (action 1) gives one result beat on the output channel
// (o_out_valid / i_out_ready), o_delay_estimate, after two passes over
// the bin memory, one read and one write port, one bin a cycle: a scoring
// pass, and a histogram pass only when the scoring pass saw a far history
// entry with any bit set. one beat is worked on at a time, so a near beat
// is not taken until the result of the last one is registered.
// config: i_cfg_we writes the delay slack from i_cfg_data; the user must
// write it only while idle, the block does not enforce this.
// reset (synchronous, active low) clears control state at once; history and
// bins read as their reset values through a fill count and valid bits, so
// no clearing pass is needed. if the receiver stalls, the result holds in
// the output register; far beats are still taken, and the next near beat
// waits at its final step until the held result is taken.
module binary_spectrum_delay_estimator_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_action,
    input  logic [31:0]      i_spectrum,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic signed [7:0] o_delay_estimate,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_data
);

    localparam int BW = bsde_pkg::BW;
    localparam int SW = bsde_pkg::SW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_P1    = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_RDREF = 4'd3;
    localparam logic [3:0] S_WREF  = 4'd4;
    localparam logic [3:0] S_P2    = 4'd5;
    localparam logic [3:0] S_RDC   = 4'd6;
    localparam logic [3:0] S_RDR   = 4'd7;
    localparam logic [3:0] S_CAPR  = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_CMP   = 4'd10;

    logic [3:0]    r_state;
    logic [BW-1:0] r_cnt;
    logic [31:0]   r_spec;
    logic [6:0]    r_ao;

    logic          r_rv;
    logic [BW-1:0] r_ridx;
    logic          r_s2_v;
    logic [BW-1:0] r_s2_idx;
    logic [14:0]   r_s2_mean;
    logic [25:0]   r_s2_hist;
    logic [5:0]    r_s2_pc;
    logic [5:0]    r_s2_p;

    logic [14:0]   r_best, r_worst, r_depth, r_minp, r_mref;
    logic [15:0]   r_lastp;
    logic [BW-1:0] r_cand, r_ref;
    logic signed [7:0] r_cur, r_prev;
    logic [10:0]   r_hit;
    logic [21:0]   r_lasth;
    logic          r_nonstat, r_inst, r_usemean;
    logic [16:0]   r_frac;
    logic signed [16:0] r_dec;
    logic [25:0]   r_hc, r_href;
    logic [42:0]   r_rhs;
    logic          r_out_v;
    logic [7:0]    r_out;

    logic          far_push;
    logic          issue;
    logic [31:0]   far_hist;
    logic [5:0]    far_pop;
    bsde_pkg::t_bin rd_bin, wr_bin;
    logic          wr_en, rd_en;
    logic [BW-1:0] wr_addr, rd_addr;

    logic [5:0]    s1_pc;
    logic [3:0]    s2_sh;
    logic signed [16:0] s2_d;
    logic [15:0]   s2_mag;
    logic [14:0]   s2_new;

    logic signed [SW-1:0] cur_s, cand_s, idx_s, diff_s;
    logic [14:0]   depth_c, thr_c, minp_c;
    logic [15:0]   lastp_c;
    logic [10:0]   hit_c;
    logic          inst_c;
    logic signed [21:0] frac_w;
    logic [16:0]   frac_c;

    logic          in_last, in_cand;
    logic signed [27:0] h_w;
    logic [25:0]   h_new;

    logic          hv, robust, cmp_go;

    assign far_push   = i_in_valid && o_in_ready && !i_action;
    assign o_in_ready = (r_state == S_IDLE);
    assign issue      = (r_state == S_P1 || r_state == S_P2)
                        && (r_cnt < BW'(bsde_pkg::NBINS));

    bsde_far_ram u_far (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (far_push),
        .i_spec  (i_spectrum),
        .i_age   (r_cnt[bsde_pkg::AW-1:0]),
        .o_hist  (far_hist),
        .o_pop   (far_pop)
    );

    bsde_bin_ram u_bin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_bin),
        .i_raddr (rd_addr),
        .o_rdata (rd_bin)
    );

    // signed views
    assign cur_s  = SW'(r_cur);
    assign cand_s = $signed(SW'(r_cand));
    assign idx_s  = $signed(SW'(r_ridx));
    assign diff_s = cand_s - cur_s;

    // scoring pass
    assign s1_pc = bsde_pkg::popcount32(r_spec ^ far_hist);

    always_comb begin
        s2_sh  = 4'(4'd13 - 4'(({1'b0, r_s2_p, 1'b0} + {2'b0, r_s2_p}) >> 4));
        s2_d   = $signed({2'b0, r_s2_pc, 9'b0}) - $signed({2'b0, r_s2_mean});
        if (s2_d < 0) begin
            s2_mag = 16'(-s2_d) >> s2_sh;
            s2_new = 15'({1'b0, r_s2_mean} - s2_mag);
        end else begin
            s2_mag = 16'(s2_d) >> s2_sh;
            s2_new = 15'({1'b0, r_s2_mean} + s2_mag);
        end
        if (r_s2_p == 6'd0) begin
            s2_new = r_s2_mean;
        end
    end

    // evaluation of the pass
    always_comb begin
        depth_c = r_worst - r_best;
        thr_c   = r_best + bsde_pkg::P_OFFSET;
        if (thr_c < bsde_pkg::P_LOWER) begin
            thr_c = bsde_pkg::P_LOWER;
        end
        minp_c = r_minp;
        if (r_minp > bsde_pkg::P_LOWER && depth_c > bsde_pkg::P_SPREAD
            && r_minp > thr_c) begin
            minp_c = thr_c;
        end
        lastp_c = (r_lastp == 16'hFFFF) ? r_lastp : r_lastp + 1'b1;
        inst_c  = depth_c > bsde_pkg::P_OFFSET
                  && ({1'b0, r_best} < {1'b0, minp_c} || {1'b0, r_best} < lastp_c);
        if (cand_s != SW'(r_prev)) begin
            hit_c = 11'd1;
        end else begin
            hit_c = (r_hit == bsde_pkg::HIT_SAT) ? r_hit : r_hit + 1'b1;
        end
        frac_w = 22'(bsde_pkg::FRAC_ONE);
        frac_c = bsde_pkg::FRAC_ONE;
        if (diff_s > $signed(SW'(r_ao))) begin
            frac_w = 22'(bsde_pkg::FRAC_ONE)
                     - $signed(22'(bsde_pkg::FRAC_SLOPE) * 22'(diff_s - $signed(SW'(r_ao))));
            frac_c = (frac_w < $signed(22'(bsde_pkg::FRAC_CAUS)))
                     ? bsde_pkg::FRAC_CAUS : 17'(frac_w);
        end else if (diff_s < 0) begin
            frac_w = 22'(bsde_pkg::FRAC_NCAUS)
                     + $signed(22'(bsde_pkg::FRAC_SLOPE) * 22'(-diff_s));
            frac_c = (frac_w > $signed(22'(bsde_pkg::FRAC_ONE)))
                     ? bsde_pkg::FRAC_ONE : 17'(frac_w);
        end
    end

    // histogram pass
    always_comb begin
        in_last = idx_s >= cur_s - SW'(2) && idx_s <= cur_s + SW'(1) && r_ridx != r_cand;
        in_cand = idx_s >= cand_s - SW'(2) && idx_s <= cand_s + SW'(1);
        h_w = $signed({2'b0, rd_bin.hist});
        if (r_ridx == r_cand) begin
            h_w = h_w + $signed(28'(r_depth));
            if (h_w > $signed({2'b0, bsde_pkg::H_MAX})) begin
                h_w = $signed({2'b0, bsde_pkg::H_MAX});
            end
        end else if (in_last) begin
            h_w = h_w - 28'(r_dec);
        end else if (!in_cand) begin
            h_w = h_w - $signed(28'(r_depth));
        end
        if (h_w < 0) begin
            h_new = '0;
        end else if (h_w > $signed({2'b0, bsde_pkg::H_SAT})) begin
            h_new = bsde_pkg::H_SAT;
        end else begin
            h_new = 26'(h_w);
        end
    end

    // validation
    always_comb begin
        hv = {r_hc, 16'b0} >= r_rhs && r_hc >= bsde_pkg::H_MINTHR
             && r_hit > bsde_pkg::MIN_HITS;
        robust = (r_cur < 0 && (r_inst || hv)) || (r_inst && hv)
                 || (hv && r_hc > {4'b0, r_lasth});
        cmp_go = !r_out_v || i_out_ready;
    end

    // bin memory ports
    always_comb begin
        unique case (r_state)
            S_RDC:   rd_addr = r_cand;
            S_P1,
            S_P2:    rd_addr = r_cnt;
            default: rd_addr = r_ref;
        endcase
        rd_en   = issue || r_state == S_RDREF || r_state == S_RDC || r_state == S_RDR;
        wr_en   = 1'b0;
        wr_addr = r_ridx;
        wr_bin  = rd_bin;
        if (r_s2_v) begin
            wr_en       = 1'b1;
            wr_addr     = r_s2_idx;
            wr_bin.mean = s2_new;
            wr_bin.hist = r_s2_hist;
        end else if (r_state == S_P2 && r_rv) begin
            wr_en       = 1'b1;
            wr_bin.hist = h_new;
        end else if (r_state == S_CMP && cmp_go && r_nonstat && robust
                     && cand_s != cur_s && r_hc < r_href) begin
            wr_en       = 1'b1;
            wr_addr     = r_ref;
            wr_bin.mean = r_mref;
            wr_bin.hist = r_hc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_ao      <= '0;
            r_rv      <= 1'b0;
            r_s2_v    <= 1'b0;
            r_minp    <= bsde_pkg::MAXQ9;
            r_lastp   <= 16'(bsde_pkg::MAXQ9);
            r_cur     <= bsde_pkg::NO_DELAY;
            r_prev    <= bsde_pkg::NO_DELAY;
            r_ref     <= BW'(bsde_pkg::NBINS);
            r_hit     <= '0;
            r_lasth   <= '0;
            r_out_v   <= 1'b0;
            r_nonstat <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ao <= i_cfg_data;
            end
            if (o_out_valid && i_out_ready && r_state != S_CMP) begin
                r_out_v <= 1'b0;
            end
            r_rv   <= issue;
            r_s2_v <= (r_state == S_P1) && r_rv;
            if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_s2_v) begin
                r_nonstat <= r_nonstat || (r_s2_p != 6'd0);
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt     <= '0;
                    r_nonstat <= 1'b0;
                    if (i_in_valid && i_action) begin
                        r_state <= S_P1;
                    end
                end
                S_P1: begin
                    if (!issue && !r_rv && !r_s2_v) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_depth <= depth_c;
                    r_minp  <= minp_c;
                    r_lastp <= lastp_c;
                    r_inst  <= inst_c;
                    r_frac  <= frac_c;
                    if (r_nonstat) begin
                        r_hit     <= hit_c;
                        r_prev    <= 8'(cand_s);
                        r_usemean <= hit_c < ((cand_s < cur_s) ? bsde_pkg::HITS_NC
                                                               : bsde_pkg::HITS_C);
                    end
                    r_state <= S_RDREF;
                end
                S_RDREF: begin
                    r_state <= S_WREF;
                end
                S_WREF: begin
                    r_cnt <= '0;
                    r_dec <= r_usemean ? $signed({2'b0, rd_bin.mean}) - $signed({2'b0, r_best})
                                       : $signed({2'b0, r_depth});
                    r_state <= r_nonstat ? S_P2 : S_RDC;
                end
                S_P2: begin
                    if (!issue && !r_rv) begin
                        r_state <= S_RDC;
                    end
                end
                S_RDC: begin
                    r_state <= S_RDR;
                end
                S_RDR: begin
                    r_hc    <= rd_bin.hist;
                    r_state <= S_CAPR;
                end
                S_CAPR: begin
                    r_href  <= rd_bin.hist;
                    r_mref  <= rd_bin.mean;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_rhs   <= 43'(r_href) * 43'(r_frac);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (cmp_go) begin
                        r_out_v <= 1'b1;
                        r_out   <= (r_nonstat && robust) ? 8'(cand_s) : r_cur;
                        if (r_nonstat && robust) begin
                            if (cand_s != cur_s) begin
                                r_lasth <= (r_hc > {4'b0, bsde_pkg::H_LASTMAX})
                                           ? bsde_pkg::H_LASTMAX : 22'(r_hc);
                            end
                            r_cur <= 8'(cand_s);
                            if ({1'b0, r_best} < r_lastp) begin
                                r_lastp <= 16'(r_best);
                            end
                            r_ref <= r_cand;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload and pass tracking
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_spec <= i_spectrum;
        end
        if (r_state == S_IDLE) begin
            r_best  <= bsde_pkg::MAXQ9;
            r_worst <= '0;
            r_cand  <= '0;
        end
        r_ridx <= r_cnt;
        if (r_rv) begin
            r_s2_idx  <= r_ridx;
            r_s2_mean <= rd_bin.mean;
            r_s2_hist <= rd_bin.hist;
            r_s2_pc   <= s1_pc;
            r_s2_p    <= far_pop;
        end
        if (r_s2_v) begin
            if (s2_new < r_best) begin
                r_best <= s2_new;
                r_cand <= r_s2_idx;
            end
            if (s2_new > r_worst) begin
                r_worst <= s2_new;
            end
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_delay_estimate = r_out;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("bin memory read and write hit the same entry");

    a_p2_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P2 && wr_en) |-> (wr_addr != BW'(bsde_pkg::NBINS)))
        else $error("histogram pass wrote the extra bin");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur >= $signed(bsde_pkg::NO_DELAY)))
        else $error("current delay below no-estimate code");

endmodule
